### sv/pwiz_pkg.sv
// ============================================================================
// pwiz_pkg - shared types and constants for the PID integral-zone unit
// Field widths, register indexes and the word formats passed between stages.
// ============================================================================
package pwiz_pkg;

    // Field widths
    localparam int ERR_W    = 24;   // error sample, signed Q15.8
    localparam int DER_W    = 25;   // error difference, one bit of growth
    localparam int INTEG_W  = 48;   // integral, signed Q39.8
    localparam int GAIN_W   = 32;   // gains, unsigned Q4.28
    localparam int LIMIT_W  = 23;   // zone and tolerance, unsigned Q15.8
    localparam int DRIVE_W  = 32;   // drive value, signed Q23.8
    localparam int SETTLE_W = 16;   // settle counter
    localparam int CFG_W    = 32;   // configuration data bus
    localparam int CFG_IDX_W = 3;

    // Product and sum widths in the back end
    localparam int PROD_E_W = GAIN_W + 1 + ERR_W;        // kp * error
    localparam int PROD_D_W = GAIN_W + 1 + DER_W;        // kd * difference
    localparam int HALF_W   = INTEG_W / 2;               // integral split point
    localparam int PROD_H_W = GAIN_W + 1 + HALF_W;       // ki * integral half
    localparam int SUM_A_W  = PROD_D_W + 1;              // kp*e + kd*d
    localparam int SUM_W    = GAIN_W + 1 + INTEG_W + 1;  // full exact sum
    localparam int FRAC_SH  = 28;                        // Q.36 -> Q.8

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd4;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [SETTLE_W-1:0] SETTLE_MAX = '1;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } pwiz_gains_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] zone;
        logic [LIMIT_W-1:0] tol;
    } pwiz_limits_t;

    // One classified sample handed from front to back
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DER_W-1:0]   deriv;
        logic [SETTLE_W-1:0]       settle;
    } pwiz_entry_t;

endpackage

### sv/pwiz_front.sv
// ============================================================================
// pwiz_front - sample intake and classification
// Tracks the band, updates integral, last error and settle run per word.
// ============================================================================
module pwiz_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic signed [pwiz_pkg::ERR_W-1:0] err,
    input  logic                         integ_clear,
    input  pwiz_pkg::pwiz_limits_t       limits,
    output pwiz_pkg::pwiz_entry_t        entry
);

    logic signed [pwiz_pkg::INTEG_W-1:0]  integ_reg, integ_next;
    logic signed [pwiz_pkg::ERR_W-1:0]    last_reg;
    logic [pwiz_pkg::SETTLE_W-1:0]        run_reg, run_next;

    logic signed [pwiz_pkg::ERR_W:0]      err_x, tol_pos, tol_neg;
    logic [pwiz_pkg::ERR_W-1:0]           mag;
    logic                                 settled, out_zone;
    logic signed [pwiz_pkg::INTEG_W:0]    sum_x;
    logic signed [pwiz_pkg::INTEG_W-1:0]  sum_sat;

    always_comb
    begin
        err_x   = {err[pwiz_pkg::ERR_W-1], err};
        tol_pos = $signed({2'b00, limits.tol});
        tol_neg = -tol_pos;
        settled = (err_x < tol_pos) && (err_x > tol_neg);
        mag     = err[pwiz_pkg::ERR_W-1] ? pwiz_pkg::ERR_W'(-err_x) : err;
        out_zone = mag > {1'b0, limits.zone};

        // Saturating add; the top two bits disagree on overflow
        sum_x = {integ_reg[pwiz_pkg::INTEG_W-1], integ_reg}
              + (pwiz_pkg::INTEG_W+1)'(err_x);
        if (sum_x[pwiz_pkg::INTEG_W] != sum_x[pwiz_pkg::INTEG_W-1])
            sum_sat = sum_x[pwiz_pkg::INTEG_W]
                    ? {1'b1, {(pwiz_pkg::INTEG_W-1){1'b0}}}
                    : {1'b0, {(pwiz_pkg::INTEG_W-1){1'b1}}};
        else
            sum_sat = sum_x[pwiz_pkg::INTEG_W-1:0];

        integ_next = (settled || out_zone) ? '0 : sum_sat;

        if (!settled)
            run_next = '0;
        else if (run_reg == pwiz_pkg::SETTLE_MAX)
            run_next = run_reg;
        else
            run_next = run_reg + 1'b1;

        entry.err    = err;
        entry.integ  = integ_next;
        entry.deriv  = err_x - {last_reg[pwiz_pkg::ERR_W-1], last_reg};
        entry.settle = run_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            last_reg  <= '0;
            run_reg   <= '0;
        end
        else if (integ_clear)
        begin
            integ_reg <= '0;
        end
        else if (take)
        begin
            integ_reg <= integ_next;
            last_reg  <= err;
            run_reg   <= run_next;
        end
    end

endmodule

### sv/pwiz_queue.sv
// ============================================================================
// pwiz_queue - short queue between intake and arithmetic
// Holds classified words so each side can stall on its own.
// ============================================================================
module pwiz_queue
#(
    parameter int DEPTH = pwiz_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pwiz_pkg::pwiz_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output pwiz_pkg::pwiz_entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    pwiz_pkg::pwiz_entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full      = cnt_reg == CNT_W'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head      = slots_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == LAST) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### sv/pwiz_back.sv
// ============================================================================
// pwiz_back - gain products, exact sum, rescale and saturate
// Three-stage arithmetic pipe followed by the output register.
// ============================================================================
module pwiz_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pwiz_pkg::pwiz_gains_t         gains,
    input  logic                          head_valid,
    input  pwiz_pkg::pwiz_entry_t         head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [pwiz_pkg::DRIVE_W-1:0] drive_value,
    output logic [pwiz_pkg::SETTLE_W-1:0] settle_count
);

    localparam int SW = pwiz_pkg::SUM_W;
    localparam int HW = pwiz_pkg::HALF_W;
    localparam int SAT_LO = pwiz_pkg::FRAC_SH + pwiz_pkg::DRIVE_W - 1;

    logic advance;

    // Stage 1: products
    logic v1_reg;
    logic signed [pwiz_pkg::PROD_E_W-1:0] pe_reg;
    logic signed [pwiz_pkg::PROD_D_W-1:0] pd_reg;
    logic signed [pwiz_pkg::PROD_H_W-1:0] pil_reg, pih_reg;
    logic [pwiz_pkg::SETTLE_W-1:0] s1_reg;

    // Stage 2: pair sums
    logic v2_reg;
    logic signed [pwiz_pkg::SUM_A_W-1:0] sa_reg;
    logic signed [SW-1:0] sb_reg;
    logic [pwiz_pkg::SETTLE_W-1:0] s2_reg;

    // Stage 3: full sum
    logic v3_reg;
    logic signed [SW-1:0] tot_reg;
    logic [pwiz_pkg::SETTLE_W-1:0] s3_reg;

    logic out_valid_reg;
    logic signed [pwiz_pkg::DRIVE_W-1:0] drive_reg, drive_next;
    logic [pwiz_pkg::SETTLE_W-1:0] settle_reg;

    logic signed [pwiz_pkg::GAIN_W:0] kp_s, ki_s, kd_s;
    logic signed [pwiz_pkg::PROD_E_W-1:0] pe_next;
    logic signed [pwiz_pkg::PROD_D_W-1:0] pd_next;
    logic signed [pwiz_pkg::PROD_H_W-1:0] pil_next, pih_next;
    logic signed [SW-1:0] pil_x, pih_x, sa_x;
    logic signed [pwiz_pkg::SUM_A_W-1:0] pe_x, pd_x;

    // Freeze the whole pipe only while a finished word is held at the output
    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && head_valid;

    always_comb
    begin
        kp_s = $signed({1'b0, gains.kp});
        ki_s = $signed({1'b0, gains.ki});
        kd_s = $signed({1'b0, gains.kd});
        pe_next  = kp_s * head.err;
        pd_next  = kd_s * head.deriv;
        pil_next = ki_s * $signed({1'b0, head.integ[HW-1:0]});
        pih_next = ki_s * $signed(head.integ[pwiz_pkg::INTEG_W-1:HW]);

        pe_x  = pwiz_pkg::SUM_A_W'(pe_reg);
        pd_x  = pwiz_pkg::SUM_A_W'(pd_reg);
        pil_x = SW'(pil_reg);
        pih_x = SW'(pih_reg) <<< HW;
        sa_x  = SW'(sa_reg);

        // floor(sum / 2^28) then clamp to 32 bits
        if (tot_reg[SW-1:SAT_LO] == {(SW-SAT_LO){tot_reg[SW-1]}})
            drive_next = tot_reg[SAT_LO:pwiz_pkg::FRAC_SH];
        else if (tot_reg[SW-1])
            drive_next = {1'b1, {(pwiz_pkg::DRIVE_W-1){1'b0}}};
        else
            drive_next = {1'b0, {(pwiz_pkg::DRIVE_W-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pe_reg     <= pe_next;
            pd_reg     <= pd_next;
            pil_reg    <= pil_next;
            pih_reg    <= pih_next;
            s1_reg     <= head.settle;
            sa_reg     <= pe_x + pd_x;
            sb_reg     <= pil_x + pih_x;
            s2_reg     <= s1_reg;
            tot_reg    <= sa_x + sb_reg;
            s3_reg     <= s2_reg;
            drive_reg  <= drive_next;
            settle_reg <= s3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= head_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign drive_value  = drive_reg;
    assign settle_count = settle_reg;

endmodule

### sv/pid_with_integral_zone_unit.sv
// ============================================================================
// pid_with_integral_zone_unit - PID controller with integral zone
// Error in, saturated PID drive and settle count out; unless stalled, one word per cycle.
// ============================================================================
//
//  channel   signals                                  word
//  -------   --------------------------------------   ----------------------
//  input     in_valid / in_stall / error_sample       Q15.8 error
//  output    out_valid / out_stall / drive_value,     Q23.8 drive and
//            settle_count                             settled-run count
//  config    cfg_we / cfg_index / cfg_data            gains, zone, tolerance
//
//  One word is accepted per cycle while the queue has room; the front-end
//  integral add-saturate-clear loop, through one register, sets that rate.
//  From input accept to output valid a word passes through the queue, products,
//  pair sums, full sum, then rescale into the output register.
//  in_stall rises only when the queue is full; the back pipe freezes while
//  a finished word sits stalled at the output, and the front keeps filling.
//  rst_n clears the config registers, queue pointers, valid flags, the integral, last error and settle run.
//  Any in-range register write also clears the integral.
//
module pid_with_integral_zone_unit
#(
    parameter int QUEUE_DEPTH = pwiz_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [pwiz_pkg::ERR_W-1:0]  error_sample,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [pwiz_pkg::DRIVE_W-1:0] drive_value,
    output logic [pwiz_pkg::SETTLE_W-1:0]      settle_count,
    input  logic                               cfg_we,
    input  logic [pwiz_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pwiz_pkg::CFG_W-1:0]         cfg_data
);

    pwiz_pkg::pwiz_gains_t  gains_reg;
    pwiz_pkg::pwiz_limits_t limits_reg;
    pwiz_pkg::pwiz_entry_t  front_entry, head;

    logic take, full, head_valid, pop, cfg_hit;

    // Hold a word at the input only while the queue has no room
    assign in_stall = full;
    assign take     = in_valid && !full;

    // Flag writes that land on a real register; those drop the integral
    always_comb
    begin
        case (cfg_index)
            pwiz_pkg::REG_GAIN_P,
            pwiz_pkg::REG_GAIN_I,
            pwiz_pkg::REG_GAIN_D,
            pwiz_pkg::REG_ZONE,
            pwiz_pkg::REG_TOLERANCE: cfg_hit = cfg_we;
            default:                 cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg  <= '0;
            limits_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pwiz_pkg::REG_GAIN_P:    gains_reg.kp    <= cfg_data;
                pwiz_pkg::REG_GAIN_I:    gains_reg.ki    <= cfg_data;
                pwiz_pkg::REG_GAIN_D:    gains_reg.kd    <= cfg_data;
                pwiz_pkg::REG_ZONE:
                    limits_reg.zone <= cfg_data[pwiz_pkg::LIMIT_W-1:0];
                pwiz_pkg::REG_TOLERANCE:
                    limits_reg.tol  <= cfg_data[pwiz_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    pwiz_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .err         (error_sample),
        .integ_clear (cfg_hit),
        .limits      (limits_reg),
        .entry       (front_entry)
    );

    pwiz_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (take),
        .push_entry (front_entry),
        .full       (full),
        .pop        (pop),
        .not_empty  (head_valid),
        .head       (head)
    );

    pwiz_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .gains        (gains_reg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive_value  (drive_value),
        .settle_count (settle_count)
    );

endmodule
